// ===== hw/rtl/ltcc_pkg.sv =====
// Shared constants, types and the keyword table of the lexical token class counter.
package ltcc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int TOTAL_W     = 32;
	localparam int WORD_BUF    = 6;
	localparam int KW_COUNT    = 8;
	localparam int LEN_W       = 3;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [TOTAL_W-1:0]     total_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [WORD_BUF-1:0][7:0] word_t;

	localparam logic [7:0] KW_TEXT [KW_COUNT][WORD_BUF] = '{
		'{"i", "n", "t", 8'h00, 8'h00, 8'h00},
		'{"f", "l", "o", "a", "t", 8'h00},
		'{"c", "h", "a", "r", 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"}
	};

	localparam len_t KW_LEN [KW_COUNT] = '{
		len_t'(3), len_t'(5), len_t'(4), len_t'(2),
		len_t'(4), len_t'(5), len_t'(3), len_t'(6)
	};

endpackage

// ===== hw/rtl/ltcc_if.sv =====
// Valid/ready channel interfaces for the text input and the totals output.
interface ltcc_text_if;
	import ltcc_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ltcc_totals_if;
	import ltcc_pkg::*;

	logic   valid;
	logic   ready;
	total_t operator_total;
	total_t separator_total;
	total_t keyword_total;
	total_t identifier_total;
	total_t constant_total;

	modport source (
		output valid, output operator_total, output separator_total,
		output keyword_total, output identifier_total, output constant_total,
		input ready
	);
	modport sink (
		input valid, input operator_total, input separator_total,
		input keyword_total, input identifier_total, input constant_total,
		output ready
	);
endinterface

// ===== hw/rtl/ltcc_kw_match.sv =====
// Compares a buffered word against the fixed keyword table.
module ltcc_kw_match
	import ltcc_pkg::*;
(
	input  word_t chars,
	input  len_t  len,
	output logic  is_kw
);

	logic [KW_COUNT-1:0] hit;

	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			hit[k] = (len == KW_LEN[k]);
			for (int i = 0; i < WORD_BUF; i++) begin
				if ((LEN_W'(i) < KW_LEN[k]) && (chars[i] != KW_TEXT[k][i])) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

	assign is_kw = |hit;

endmodule

// ===== hw/rtl/lexical_token_class_counter_unit.sv =====
// Top level of the lexical token class counter: byte scanner, counters and result register.
//
//   channel  direction  contents
//   text     in         text_byte, end_of_text
//   totals   out        operator, separator, keyword, identifier and constant totals
//
// One byte is accepted per cycle while the input is not stalled; the scanner state updates
// from the input register, so back-to-back requests are taken unless the input stalls.
// A request carrying end_of_text passes through the input register, then its totals are
// held in the result register and presented on the totals channel.
// Reset clears the scanner and all counters at once; no clearing pass is needed.
// Input stalls only while the input register holds a final byte and the result
// register still holds the previous totals that have not been taken.
module lexical_token_class_counter_unit
	import ltcc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	ltcc_text_if.sink       text,
	ltcc_totals_if.source   totals
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM
	} mode_t;

	function automatic cnt_t sat_inc(input cnt_t c, input logic en);
		cnt_t r;
		r = c;
		if (en && (c != '1)) begin
			r = c + cnt_t'(1);
		end
		return r;
	endfunction

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	mode_t mode_q;
	word_t chars_q;
	len_t  len_q;
	cnt_t  op_cnt_q, sep_cnt_q, kw_cnt_q, id_cnt_q, con_cnt_q;

	logic   out_valid_q;
	total_t op_tot_q, sep_tot_q, kw_tot_q, id_tot_q, con_tot_q;

	logic stall, fire;
	logic is_letter, is_digit, is_under, is_op, is_sep, word_char;
	logic kw_old, kw_new;
	mode_t mode_step;
	word_t chars_step;
	len_t  len_step;
	logic op_f, sep_f, kw_f, id_f, con_f;
	cnt_t op_next, sep_next, kw_next, id_next, con_next;

	assign stall      = valid_s1 && last_s1 && out_valid_q && !totals.ready;
	assign fire       = valid_s1 && !stall;
	assign text.ready = !stall;

	assign is_letter = ((byte_s1 >= "a") && (byte_s1 <= "z")) ||
		((byte_s1 >= "A") && (byte_s1 <= "Z"));
	assign is_digit  = (byte_s1 >= "0") && (byte_s1 <= "9");
	assign is_under  = (byte_s1 == "_");
	assign is_op     = (byte_s1 == "+") || (byte_s1 == "-") ||
		(byte_s1 == "*") || (byte_s1 == "/");
	assign is_sep    = (byte_s1 == ";") || (byte_s1 == ",") || (byte_s1 == "{") ||
		(byte_s1 == "}") || (byte_s1 == "(") || (byte_s1 == ")");
	assign word_char = is_letter || is_digit || is_under;

	ltcc_kw_match u_kw_old (
		.chars (chars_q),
		.len   (len_q),
		.is_kw (kw_old)
	);

	ltcc_kw_match u_kw_new (
		.chars (chars_step),
		.len   (len_step),
		.is_kw (kw_new)
	);

	// The byte that closes a token is classified on its own, so a new token may open.
	always_comb begin
		logic start;
		start      = 1'b0;
		mode_step  = mode_q;
		chars_step = chars_q;
		len_step   = len_q;
		op_f       = 1'b0;
		sep_f      = 1'b0;
		kw_f       = 1'b0;
		id_f       = 1'b0;
		con_f      = 1'b0;
		case (mode_q)
			MODE_WORD: begin
				if (word_char) begin
					for (int i = 0; i < WORD_BUF; i++) begin
						if (LEN_W'(i) == len_q) begin
							chars_step[i] = byte_s1;
						end
					end
					if (len_q != '1) begin
						len_step = len_q + len_t'(1);
					end
				end else begin
					kw_f  = kw_old;
					id_f  = !kw_old;
					start = 1'b1;
				end
			end
			MODE_NUM: begin
				if (!(is_digit || (byte_s1 == "."))) begin
					con_f = 1'b1;
					start = 1'b1;
				end
			end
			default: begin
				start = 1'b1;
			end
		endcase
		if (start) begin
			mode_step  = MODE_IDLE;
			chars_step = '0;
			len_step   = '0;
			op_f       = is_op;
			sep_f      = is_sep;
			if (is_letter || is_under) begin
				mode_step     = MODE_WORD;
				chars_step[0] = byte_s1;
				len_step      = len_t'(1);
			end else if (is_digit) begin
				mode_step = MODE_NUM;
			end
		end
		// A word or number still open at the final byte is counted now.
		if (last_s1) begin
			if (mode_step == MODE_WORD) begin
				kw_f = kw_f || kw_new;
				id_f = id_f || !kw_new;
			end else if (mode_step == MODE_NUM) begin
				con_f = 1'b1;
			end
		end
	end

	assign op_next  = sat_inc(op_cnt_q, op_f);
	assign sep_next = sat_inc(sep_cnt_q, sep_f);
	assign kw_next  = sat_inc(kw_cnt_q, kw_f);
	assign id_next  = sat_inc(id_cnt_q, id_f);
	assign con_next = sat_inc(con_cnt_q, con_f);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			chars_q   <= '0;
			len_q     <= '0;
			op_cnt_q  <= '0;
			sep_cnt_q <= '0;
			kw_cnt_q  <= '0;
			id_cnt_q  <= '0;
			con_cnt_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				mode_q    <= MODE_IDLE;
				chars_q   <= '0;
				len_q     <= '0;
				op_cnt_q  <= '0;
				sep_cnt_q <= '0;
				kw_cnt_q  <= '0;
				id_cnt_q  <= '0;
				con_cnt_q <= '0;
			end else begin
				mode_q    <= mode_step;
				chars_q   <= chars_step;
				len_q     <= len_step;
				op_cnt_q  <= op_next;
				sep_cnt_q <= sep_next;
				kw_cnt_q  <= kw_next;
				id_cnt_q  <= id_next;
				con_cnt_q <= con_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (totals.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_s1) begin
			op_tot_q  <= TOTAL_W'(op_next);
			sep_tot_q <= TOTAL_W'(sep_next);
			kw_tot_q  <= TOTAL_W'(kw_next);
			id_tot_q  <= TOTAL_W'(id_next);
			con_tot_q <= TOTAL_W'(con_next);
		end
	end

	assign totals.valid            = out_valid_q;
	assign totals.operator_total   = op_tot_q;
	assign totals.separator_total  = sep_tot_q;
	assign totals.keyword_total    = kw_tot_q;
	assign totals.identifier_total = id_tot_q;
	assign totals.constant_total   = con_tot_q;

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> (mode_q == MODE_IDLE) && (len_q == '0) && (op_cnt_q == '0))
		else $error("scanner state not cleared after the final byte");

	a_final_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> out_valid_q)
		else $error("final byte did not produce a result");

	a_len_mode: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_WORD |-> len_q == '0)
		else $error("word length nonzero outside a word");

	a_empty_buf: assert property (@(posedge clk) disable iff (!arst_n)
		len_q == '0 |-> chars_q == '0)
		else $error("word buffer not empty at length zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!text.ready |-> valid_s1 && last_s1 && out_valid_q)
		else $error("input stalled without a pending final byte");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking lexical token class counter bench: directed table, stall burst, random texts.
module tb_top;
	import ltcc_pkg::*;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_mode_t;

	typedef struct packed {
		total_t operators;
		total_t separators;
		total_t keywords;
		total_t identifiers;
		total_t constants;
	} totals_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last;
		logic       literal;
		totals_t    want;
	} text_row_t;

	localparam int      CLK_HALF       = 10;
	localparam int      RESET_CYCLES   = 5;
	localparam int      RANDOM_ITEMS   = 1350;
	localparam int      IDLE_PERCENT   = 29;
	localparam int      RX_HOLD_CYCLES = 300;
	localparam int      DRAIN_CYCLES   = 20;
	localparam int      CYCLE_LIMIT    = 400000;
	localparam int      DIRECTED_ROWS  = 27;
	localparam int      MAX_WORD_LEN   = 7;
	localparam totals_t NO_TOTALS      = '0;

	logic clk;
	logic arst_n;

	ltcc_text_if   text_ch ();
	ltcc_totals_if totals_ch ();

	lexical_token_class_counter_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.totals (totals_ch)
	);

	string keywords [8] = '{"int", "float", "char", "if", "else", "while", "for", "return"};
	string field_names [5] = '{"operator_total", "separator_total", "keyword_total",
		"identifier_total", "constant_total"};
	string operator_chars  = "+-*/";
	string separator_chars = ";,{}()";

	text_row_t directed_rows [DIRECTED_ROWS] = '{
		{8'h00, 1'b1, 1'b1, NO_TOTALS},
		{8'hFF, 1'b1, 1'b1, NO_TOTALS},
		{"i", 1'b0, 1'b0, NO_TOTALS},
		{"f", 1'b0, 1'b0, NO_TOTALS},
		{"(", 1'b0, 1'b0, NO_TOTALS},
		{"_", 1'b0, 1'b0, NO_TOTALS},
		{"9", 1'b0, 1'b0, NO_TOTALS},
		{")", 1'b0, 1'b0, NO_TOTALS},
		{"{", 1'b0, 1'b0, NO_TOTALS},
		{"7", 1'b0, 1'b0, NO_TOTALS},
		{".", 1'b0, 1'b0, NO_TOTALS},
		{"-", 1'b0, 1'b0, NO_TOTALS},
		{"*", 1'b0, 1'b0, NO_TOTALS},
		{"/", 1'b0, 1'b0, NO_TOTALS},
		{",", 1'b0, 1'b0, NO_TOTALS},
		{"}", 1'b0, 1'b0, NO_TOTALS},
		{";", 1'b0, 1'b0, NO_TOTALS},
		{"+", 1'b1, 1'b0, NO_TOTALS},
		{"r", 1'b0, 1'b0, NO_TOTALS},
		{"e", 1'b0, 1'b0, NO_TOTALS},
		{"t", 1'b0, 1'b0, NO_TOTALS},
		{"u", 1'b0, 1'b0, NO_TOTALS},
		{"r", 1'b0, 1'b0, NO_TOTALS},
		{"n", 1'b0, 1'b0, NO_TOTALS},
		{"s", 1'b0, 1'b0, NO_TOTALS},
		{8'h80, 1'b0, 1'b0, NO_TOTALS},
		{"9", 1'b1, 1'b0, NO_TOTALS}
	};

	scan_mode_t scan_mode = SCAN_IDLE;
	logic [7:0] word_buf [WORD_BUF] = '{WORD_BUF{8'h00}};
	int         word_len = 0;
	cnt_t       n_operators = '0;
	cnt_t       n_separators = '0;
	cnt_t       n_keywords = '0;
	cnt_t       n_identifiers = '0;
	cnt_t       n_constants = '0;

	totals_t    pending_totals [$];
	logic [7:0] text_bytes [$];
	int         fail_count = 0;
	int         items_sent = 0;
	int         cycle_count = 0;
	bit         idle_enable = 1'b1;
	bit         rx_hold_req = 1'b0;

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic cnt_t bump(input cnt_t c);
		return (c == '1) ? c : cnt_t'(c + 1'b1);
	endfunction

	function automatic logic [7:0] random_word_char(input bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26) begin
			return 8'("a" + r);
		end else if (r < 52) begin
			return 8'("A" + r - 26);
		end else if (r == 52) begin
			return "_";
		end
		return 8'("0" + r - 53);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic close_token();
		bit hit;
		bit same;
		hit = 1'b0;
		if (scan_mode == SCAN_WORD) begin
			foreach (keywords[k]) begin
				if (word_len == keywords[k].len()) begin
					same = 1'b1;
					for (int i = 0; i < keywords[k].len(); i++) begin
						if (word_buf[i] != keywords[k][i]) begin
							same = 1'b0;
						end
					end
					if (same) begin
						hit = 1'b1;
					end
				end
			end
			if (hit) begin
				n_keywords = bump(n_keywords);
			end else begin
				n_identifiers = bump(n_identifiers);
			end
		end else if (scan_mode == SCAN_NUMBER) begin
			n_constants = bump(n_constants);
		end
		scan_mode = SCAN_IDLE;
		word_len = 0;
		foreach (word_buf[i]) begin
			word_buf[i] = 8'h00;
		end
	endtask

	task automatic start_token(input logic [7:0] b);
		if (b == "+" || b == "-" || b == "*" || b == "/") begin
			n_operators = bump(n_operators);
		end else if (b == ";" || b == "," || b == "{" || b == "}" || b == "(" || b == ")") begin
			n_separators = bump(n_separators);
		end else if (is_letter(b) || b == "_") begin
			scan_mode = SCAN_WORD;
			word_buf[0] = b;
			word_len = 1;
		end else if (is_digit(b)) begin
			scan_mode = SCAN_NUMBER;
		end
	endtask

	task automatic count_byte(input logic [7:0] b, input logic last, output bit done,
		output totals_t t);
		done = 1'b0;
		t = NO_TOTALS;
		case (scan_mode)
			SCAN_WORD: begin
				if (is_letter(b) || is_digit(b) || b == "_") begin
					if (word_len < WORD_BUF) begin
						word_buf[word_len] = b;
					end
					if (word_len < MAX_WORD_LEN) begin
						word_len++;
					end
				end else begin
					close_token();
					start_token(b);
				end
			end
			SCAN_NUMBER: begin
				if (!(is_digit(b) || b == ".")) begin
					close_token();
					start_token(b);
				end
			end
			default: begin
				scan_mode = SCAN_IDLE;
				start_token(b);
			end
		endcase
		if (last) begin
			close_token();
			done = 1'b1;
			t = {total_t'(n_operators), total_t'(n_separators), total_t'(n_keywords),
				total_t'(n_identifiers), total_t'(n_constants)};
			n_operators = '0;
			n_separators = '0;
			n_keywords = '0;
			n_identifiers = '0;
			n_constants = '0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input logic literal,
		input totals_t want);
		bit      done;
		totals_t t;
		while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.end_of_text <= last;
		@(posedge clk);
		while (text_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		items_sent++;
		count_byte(b, last, done, t);
		if (done) begin
			pending_totals.push_back(literal ? want : t);
		end
	endtask

	task automatic drain_totals();
		text_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_totals.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// The receiver holds ready low for a long stretch when asked, so the block backs up.
	initial begin
		int      hold_left;
		totals_t got;
		totals_t want;
		hold_left = 0;
		totals_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (totals_ch.valid === 1'b1 && totals_ch.ready === 1'b1) begin
				got = {totals_ch.operator_total, totals_ch.separator_total,
					totals_ch.keyword_total, totals_ch.identifier_total,
					totals_ch.constant_total};
				if (pending_totals.size() == 0) begin
					report_mismatch("totals arrived with no text pending");
				end else begin
					want = pending_totals.pop_front();
					for (int f = 0; f < 5; f++) begin
						if (got[TOTAL_W*(4-f) +: TOTAL_W] !== want[TOTAL_W*(4-f) +: TOTAL_W]) begin
							report_mismatch($sformatf("%s got %0d, want %0d", field_names[f],
								got[TOTAL_W*(4-f) +: TOTAL_W], want[TOTAL_W*(4-f) +: TOTAL_W]));
						end
					end
				end
			end
			if (rx_hold_req) begin
				hold_left = RX_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				totals_ch.ready <= 1'b0;
			end else begin
				totals_ch.ready <= !(idle_enable && $urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	initial begin
		int    texts;
		int    stop_at;
		string kw;
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= 8'h00;
		text_ch.end_of_text <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_byte(directed_rows[i].text_byte, directed_rows[i].last,
				directed_rows[i].literal, directed_rows[i].want);
		end
		drain_totals();

		// Many short texts against a stalled receiver fill the result path.
		rx_hold_req = 1'b1;
		repeat (12) begin
			send_byte("x", 1'b0, 1'b0, NO_TOTALS);
			send_byte(";", 1'b1, 1'b0, NO_TOTALS);
		end
		drain_totals();

		texts = 0;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			idle_enable = !(texts >= 20 && texts < 32);
			text_bytes.delete();
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 8)) begin
					kw = keywords[$urandom_range(0, 7)];
					case ($urandom_range(0, 9))
						0, 1: begin
							for (int i = 0; i < kw.len(); i++) text_bytes.push_back(kw[i]);
						end
						2: begin
							case ($urandom_range(0, 2))
								0: begin
									for (int i = 0; i < kw.len() - 1; i++) begin
										text_bytes.push_back(kw[i]);
									end
								end
								1: begin
									for (int i = 0; i < kw.len(); i++) text_bytes.push_back(kw[i]);
									text_bytes.push_back(random_word_char(1'b0));
								end
								default: begin
									text_bytes.push_back(kw[0] ^ 8'h20);
									for (int i = 1; i < kw.len(); i++) text_bytes.push_back(kw[i]);
								end
							endcase
						end
						3, 4: begin
							text_bytes.push_back(random_word_char(1'b1));
							repeat ($urandom_range(0, 8)) text_bytes.push_back(random_word_char(1'b0));
						end
						5: begin
							text_bytes.push_back(8'("0" + $urandom_range(0, 9)));
							repeat ($urandom_range(0, 5)) begin
								text_bytes.push_back(($urandom_range(3) == 0) ? "." :
									8'("0" + $urandom_range(0, 9)));
							end
						end
						6: text_bytes.push_back(operator_chars[$urandom_range(0, 3)]);
						7: text_bytes.push_back(separator_chars[$urandom_range(0, 5)]);
						8: begin
							case ($urandom_range(0, 2))
								0: text_bytes.push_back(8'h20);
								1: text_bytes.push_back(8'h09);
								default: text_bytes.push_back(8'h0A);
							endcase
						end
						default: text_bytes.push_back(8'($urandom_range(0, 255)));
					endcase
					if ($urandom_range(1) == 1) begin
						text_bytes.push_back(8'h20);
					end
				end
			end
			foreach (text_bytes[i]) begin
				send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_TOTALS);
			end
			texts++;
			if (texts % 15 == 0) begin
				drain_totals();
			end
		end

		idle_enable = 1'b1;
		drain_totals();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
